// ===== rtl/core/psbtgm_pkg.sv =====
`timescale 1ns / 1ps

package psbtgm_pkg;

   localparam logic [15:0] RECORD_LIMIT = 16'hFFFF;
   localparam logic [23:0] MAX_FILE_BYTES_RESET = 24'd65536;

   localparam logic [7:0] MAGIC_0 = 8'h70;
   localparam logic [7:0] MAGIC_1 = 8'h73;
   localparam logic [7:0] MAGIC_2 = 8'h62;
   localparam logic [7:0] MAGIC_3 = 8'h74;
   localparam logic [7:0] MAGIC_4 = 8'hFF;
   localparam logic [2:0] MAGIC_LEN = 3'd5;

   localparam logic [7:0]  CS_PREFIX_16 = 8'hFD;
   localparam logic [7:0]  CS_PREFIX_32 = 8'hFE;
   localparam logic [31:0] CS_MIN_16    = 32'h0000_00FD;
   localparam logic [31:0] CS_MAX_BELOW_32 = 32'h0000_FFFF;
   localparam logic [2:0]  CS_BYTES_16  = 3'd2;
   localparam logic [2:0]  CS_BYTES_32  = 3'd4;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      PH_MAGIC   = 3'd0,
      PH_KEYLEN  = 3'd1,
      PH_KEYBODY = 3'd2,
      PH_VALLEN  = 3'd3,
      PH_VALBODY = 3'd4,
      PH_DONE    = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_TOOLARGE = 3'd2,
      ST_BADMAGIC = 3'd3,
      ST_TRUNC    = 3'd4,
      ST_NONCANON = 3'd5,
      ST_NOTERM   = 3'd6
   } status_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       byte_present;
      logic       is_last;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] total_bytes;
      logic [31:0] map_bytes;
      logic [15:0] record_total;
   } rsp_item_type;

   function automatic logic magic_match(input logic [2:0] idx, input logic [7:0] b);
      logic m;
      case (idx)
         3'd0: m = (b == MAGIC_0);
         3'd1: m = (b == MAGIC_1);
         3'd2: m = (b == MAGIC_2);
         3'd3: m = (b == MAGIC_3);
         3'd4: m = (b == MAGIC_4);
         default: m = 1'b0;
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/core/psbtgm_parser.sv =====
`timescale 1ns / 1ps

module psbtgm_parser
   import psbtgm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  logic [23:0]  max_file_bytes,
   output rsp_item_type result
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  magic_idx_ff, magic_idx_in;
   logic [2:0]  size_idx_ff, size_idx_in;
   logic [2:0]  size_need_ff, size_need_in;
   logic [31:0] size_acc_ff, size_acc_in;
   logic [31:0] skip_ff, skip_in;
   status_type  verdict_ff, verdict_in;
   logic        latched_ff, latched_in;
   logic [31:0] byte_cnt_ff, byte_cnt_in;
   logic [31:0] map_cnt_ff, map_cnt_in;
   logic [15:0] rec_cnt_ff, rec_cnt_in;

   always_comb begin
      logic [31:0] size_val;
      logic [31:0] acc_next;
      logic [2:0]  idx_next;
      logic        size_ready;
      logic        rec_finish;
      logic [31:0] skip_next;
      status_type  st;

      phase_in     = phase_ff;
      magic_idx_in = magic_idx_ff;
      size_idx_in  = size_idx_ff;
      size_need_in = size_need_ff;
      size_acc_in  = size_acc_ff;
      skip_in      = skip_ff;
      verdict_in   = verdict_ff;
      latched_in   = latched_ff;
      byte_cnt_in  = byte_cnt_ff;
      map_cnt_in   = map_cnt_ff;
      rec_cnt_in   = rec_cnt_ff;
      size_val     = 32'd0;
      acc_next     = size_acc_ff | ({24'd0, item.byte_value} << {size_idx_ff[1:0], 3'b000});
      idx_next     = size_idx_ff + 3'd1;
      size_ready   = 1'b0;
      rec_finish   = 1'b0;
      skip_next    = skip_ff - 32'd1;

      if (item.byte_present) begin
         if (byte_cnt_ff != COUNT_MAX) begin
            byte_cnt_in = byte_cnt_ff + 32'd1;
         end
         if (!latched_ff && phase_ff != PH_DONE) begin
            if (phase_ff == PH_MAGIC) begin
               if (magic_idx_ff >= MAGIC_LEN || !magic_match(magic_idx_ff, item.byte_value)) begin
                  verdict_in = ST_BADMAGIC;
                  latched_in = 1'b1;
               end else begin
                  magic_idx_in = magic_idx_ff + 3'd1;
                  if (magic_idx_in == MAGIC_LEN) begin
                     phase_in = PH_KEYLEN;
                  end
               end
            end else begin
               if (map_cnt_ff != COUNT_MAX) begin
                  map_cnt_in = map_cnt_ff + 32'd1;
               end
               case (phase_ff)
                  PH_KEYLEN, PH_VALLEN: begin
                     if (size_need_ff == 3'd0) begin
                        if (item.byte_value < CS_PREFIX_16) begin
                           size_val   = {24'd0, item.byte_value};
                           size_ready = 1'b1;
                        end else if (item.byte_value == CS_PREFIX_16) begin
                           size_need_in = CS_BYTES_16;
                        end else if (item.byte_value == CS_PREFIX_32) begin
                           size_need_in = CS_BYTES_32;
                        end else begin
                           verdict_in = ST_TOOLARGE;
                           latched_in = 1'b1;
                        end
                     end else begin
                        size_acc_in = acc_next;
                        size_idx_in = idx_next;
                        if (idx_next >= size_need_ff) begin
                           if ((size_need_ff == CS_BYTES_16 && acc_next < CS_MIN_16) ||
                               (size_need_ff == CS_BYTES_32 && acc_next <= CS_MAX_BELOW_32)) begin
                              verdict_in = ST_NONCANON;
                              latched_in = 1'b1;
                           end else begin
                              size_val   = acc_next;
                              size_ready = 1'b1;
                           end
                        end
                     end
                     if (size_ready) begin
                        size_idx_in  = 3'd0;
                        size_need_in = 3'd0;
                        size_acc_in  = 32'd0;
                        if (size_val == 32'd0) begin
                           if (phase_ff == PH_KEYLEN) begin
                              phase_in = PH_DONE;
                           end else begin
                              rec_finish = 1'b1;
                           end
                        end else begin
                           skip_in  = size_val;
                           phase_in = (phase_ff == PH_KEYLEN) ? PH_KEYBODY : PH_VALBODY;
                        end
                     end
                  end
                  PH_KEYBODY: begin
                     skip_in = skip_next;
                     if (skip_next == 32'd0) begin
                        phase_in = PH_VALLEN;
                     end
                  end
                  PH_VALBODY: begin
                     skip_in = skip_next;
                     if (skip_next == 32'd0) begin
                        rec_finish = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               if (rec_finish) begin
                  // record limit reached: latch and hold the phase
                  if (rec_cnt_ff >= RECORD_LIMIT) begin
                     verdict_in = ST_TOOLARGE;
                     latched_in = 1'b1;
                  end else begin
                     rec_cnt_in = rec_cnt_ff + 16'd1;
                     phase_in   = PH_KEYLEN;
                  end
               end
            end
         end
      end

      if (byte_cnt_in == 32'd0) begin
         st = ST_EMPTY;
      end else if (byte_cnt_in > {8'd0, max_file_bytes}) begin
         st = ST_TOOLARGE;
      end else if (latched_in) begin
         st = verdict_in;
      end else if (phase_in == PH_MAGIC) begin
         st = ST_BADMAGIC;
      end else if (phase_in == PH_DONE) begin
         st = ST_OK;
      end else if (phase_in == PH_KEYLEN && size_need_in == 3'd0) begin
         st = ST_NOTERM;
      end else begin
         st = ST_TRUNC;
      end

      result.status       = st;
      result.total_bytes  = byte_cnt_in;
      result.map_bytes    = (st == ST_OK) ? map_cnt_in : 32'd0;
      result.record_total = rec_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.is_last)) begin
         phase_ff     <= PH_MAGIC;
         magic_idx_ff <= 3'd0;
         size_idx_ff  <= 3'd0;
         size_need_ff <= 3'd0;
         size_acc_ff  <= 32'd0;
         skip_ff      <= 32'd0;
         verdict_ff   <= ST_OK;
         latched_ff   <= 1'b0;
         byte_cnt_ff  <= 32'd0;
         map_cnt_ff   <= 32'd0;
         rec_cnt_ff   <= 16'd0;
      end else if (step) begin
         phase_ff     <= phase_in;
         magic_idx_ff <= magic_idx_in;
         size_idx_ff  <= size_idx_in;
         size_need_ff <= size_need_in;
         size_acc_ff  <= size_acc_in;
         skip_ff      <= skip_in;
         verdict_ff   <= verdict_in;
         latched_ff   <= latched_in;
         byte_cnt_ff  <= byte_cnt_in;
         map_cnt_ff   <= map_cnt_in;
         rec_cnt_ff   <= rec_cnt_in;
      end
   end

endmodule

// ===== rtl/core/psbt_global_map_envelope_check.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Payload           Handshake
// req_      in         req_item_type     req_valid / req_ready
// rsp_      out        rsp_item_type     rsp_valid / rsp_ready
// csr_      in         csr_data [23:0]   csr_valid / csr_ready
//
// One beat per cycle unless a last beat is held for rsp_ready: a beat waits in the
// input register, is parsed by the byte walker and, on the last beat of a file, is
// registered in the result register as it advances, and is offered on rsp_ from there.
// Reset clears the walker and loads max_file_bytes with 65536.
// Only last beats wait on rsp_ready; other beats pass while a result stalls.

module psbt_global_map_envelope_check
   import psbtgm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [23:0]  csr_data
);

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   logic [23:0]  max_bytes_ff;
   logic         advance;
   rsp_item_type result;

   // hold a last beat while the previous result is still waiting
   assign advance   = in_valid_ff && (!in_item_ff.is_last || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   psbtgm_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .item           (in_item_ff),
      .max_file_bytes (max_bytes_ff),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_bytes_ff <= MAX_FILE_BYTES_RESET;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance && in_item_ff.is_last) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            max_bytes_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
      if (advance && in_item_ff.is_last) begin
         out_item_ff <= result;
      end
   end

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance && in_item_ff.is_last |=> out_valid_ff)
      else $error("last beat produced no result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !(advance && in_item_ff.is_last))
      else $error("pending result overwritten");

   a_map_within_file: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_item_ff.map_bytes <= out_item_ff.total_bytes)
      else $error("map bytes exceed file bytes");

   a_map_only_ok: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.status != ST_OK |-> out_item_ff.map_bytes == 32'd0)
      else $error("map bytes reported on failed file");

   a_ok_has_terminator: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.status == ST_OK |-> out_item_ff.map_bytes != 32'd0)
      else $error("ok result without terminator byte");

endmodule
